[rtl/swfr_pkg.sv]
// Shared constants for the sync-word frame receiver with checksum.
`default_nettype none

package swfr_pkg;

   // Default total frame length in bytes, sync word included.
   localparam int unsigned FRAME_LEN_DEF = 128;

   // Number of bytes in the sync word.
   localparam int unsigned SYNC_LEN = 4;

   // Sync word bytes, first byte at index 0.
   localparam logic [SYNC_LEN-1:0][7:0] SYNC_WORD = {8'h78, 8'h56, 8'h34, 8'h12};

   // Sync position codes: hunting for the first byte, at the last sync byte, and inside the frame body.
   localparam logic [2:0] SYNC_POS_HUNT = 3'd0;
   localparam logic [2:0] SYNC_POS_LAST = 3'd3;
   localparam logic [2:0] SYNC_POS_BODY = 3'd4;

endpackage : swfr_pkg

`default_nettype wire

[rtl/sync_word_frame_receiver_checksum_top.sv]
// An item accepted into the input register moves on to the result register and the
// rsp_ ports, unless rsp_stall holds the result register.
// Throughput: one item per cycle unless stalled; one input and one result register,
// with the whole per-byte update (two 8-bit adds and compares) between them.
// Reset (synchronous, active high) empties both registers, returns to hunting for
// the first sync byte, and clears the byte counter, both sums and the check flag.
`default_nettype none

module sync_word_frame_receiver_checksum_top #(
   parameter int unsigned FRAME_LEN = swfr_pkg::FRAME_LEN_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_data_byte,
   output logic [7:0]      rsp_byte_index,
   output logic            rsp_in_frame,
   output logic            rsp_frame_end,
   output logic            rsp_frame_good
);

   // Body index of the first check byte, held one bit wider than the byte counter.
   localparam logic [8:0] CHK1_IDX = 9'(FRAME_LEN - 2);
   localparam logic [7:0] SYNC_BODY_CNT = 8'(swfr_pkg::SYNC_LEN);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic [2:0] sync_pos_ff, sync_pos_in;
   logic [7:0] byte_cnt_ff, byte_cnt_in;
   logic [7:0] run_sum_ff, run_sum_in;
   logic [7:0] sos_ff, sos_in;
   logic       first_ok_ff, first_ok_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [7:0] rsp_index_ff, rsp_index_in;
   logic       rsp_in_frame_ff, rsp_in_frame_in;
   logic       rsp_end_ff, rsp_end_in;
   logic       rsp_good_ff, rsp_good_in;

   logic       out_free;
   logic       in_free;
   logic       step;

   // Pipeline flow: the result register frees when empty or taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_free   = !in_valid_ff || out_free;
   assign step      = in_valid_ff && out_free;
   assign req_stall = !in_free;

   // Per-byte update of the sync hunt, frame counter and checksums.
   always_comb begin
      logic [2:0] pos;
      logic [7:0] base_rs;
      logic [7:0] base_ss;
      logic [7:0] acc_rs;
      logic [8:0] idx_wide;

      pos         = (sync_pos_ff > swfr_pkg::SYNC_POS_BODY) ? swfr_pkg::SYNC_POS_HUNT
                                                            : sync_pos_ff;
      sync_pos_in = pos;
      byte_cnt_in = byte_cnt_ff;
      run_sum_in  = run_sum_ff;
      sos_in      = sos_ff;
      first_ok_in = first_ok_ff;
      base_rs     = run_sum_ff;
      base_ss     = sos_ff;
      idx_wide    = {1'b0, byte_cnt_ff};

      rsp_data_in     = in_byte_ff;
      rsp_index_in    = byte_cnt_ff;
      rsp_in_frame_in = 1'b0;
      rsp_end_in      = 1'b0;
      rsp_good_in     = 1'b0;

      if (pos != swfr_pkg::SYNC_POS_BODY) begin
         // Hunting: a fresh hunt starts from cleared sums.
         rsp_index_in = {5'd0, pos};
         if (pos == swfr_pkg::SYNC_POS_HUNT) begin
            base_rs     = 8'd0;
            base_ss     = 8'd0;
            first_ok_in = 1'b0;
         end
         acc_rs = base_rs + in_byte_ff;
         if (in_byte_ff == swfr_pkg::SYNC_WORD[pos[1:0]]) begin
            run_sum_in  = acc_rs;
            sos_in      = base_ss + acc_rs;
            sync_pos_in = pos + 3'd1;
            if (pos == swfr_pkg::SYNC_POS_LAST) begin
               byte_cnt_in = SYNC_BODY_CNT;
            end
         end else begin
            sync_pos_in = swfr_pkg::SYNC_POS_HUNT;
            run_sum_in  = 8'd0;
            sos_in      = 8'd0;
            first_ok_in = 1'b0;
         end
      end else begin
         // Frame body: accumulate, then check the two trailing bytes.
         acc_rs          = run_sum_ff + in_byte_ff;
         rsp_in_frame_in = 1'b1;
         if (idx_wide < CHK1_IDX) begin
            run_sum_in = acc_rs;
            sos_in     = sos_ff + acc_rs;
         end else if (idx_wide == CHK1_IDX) begin
            first_ok_in = (in_byte_ff == run_sum_ff);
         end else begin
            rsp_end_in  = 1'b1;
            rsp_good_in = first_ok_ff && (in_byte_ff == sos_ff);
            sync_pos_in = swfr_pkg::SYNC_POS_HUNT;
            run_sum_in  = 8'd0;
            sos_in      = 8'd0;
            first_ok_in = 1'b0;
         end
         byte_cnt_in = byte_cnt_ff + 8'd1;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
      if (in_free && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Receiver state, advanced once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_pos_ff <= swfr_pkg::SYNC_POS_HUNT;
         byte_cnt_ff <= 8'd0;
         run_sum_ff  <= 8'd0;
         sos_ff      <= 8'd0;
         first_ok_ff <= 1'b0;
      end else if (step) begin
         sync_pos_ff <= sync_pos_in;
         byte_cnt_ff <= byte_cnt_in;
         run_sum_ff  <= run_sum_in;
         sos_ff      <= sos_in;
         first_ok_ff <= first_ok_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (step) begin
         rsp_data_ff     <= rsp_data_in;
         rsp_index_ff    <= rsp_index_in;
         rsp_in_frame_ff <= rsp_in_frame_in;
         rsp_end_ff      <= rsp_end_in;
         rsp_good_ff     <= rsp_good_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_in_frame   = rsp_in_frame_ff;
   assign rsp_frame_end  = rsp_end_ff;
   assign rsp_frame_good = rsp_good_ff;

endmodule : sync_word_frame_receiver_checksum_top

`default_nettype wire

[rtl/swfr_checker.sv]
// Port-level assertions for the frame receiver, bound to the top level.
`default_nettype none

module swfr_checker #(
   parameter int unsigned FRAME_LEN = swfr_pkg::FRAME_LEN_DEF
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [7:0] req_rx_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_data_byte,
   input wire logic [7:0] rsp_byte_index,
   input wire logic       rsp_in_frame,
   input wire logic       rsp_frame_end,
   input wire logic       rsp_frame_good
);

   localparam logic [7:0] LAST_IDX = 8'(FRAME_LEN - 1);
   localparam logic [7:0] SYNC_CNT = 8'(swfr_pkg::SYNC_LEN);

   // A good-frame flag only appears on the last byte of a frame.
   a_good_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_good |-> rsp_frame_end)
      else $error("frame_good without frame_end");

   // The last byte of a frame is a body byte at the final index.
   a_end_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_in_frame && rsp_byte_index == LAST_IDX)
      else $error("frame_end at wrong position");

   // Sync bytes carry an index below the sync length; body bytes at or above it.
   a_sync_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_in_frame ? rsp_byte_index >= SYNC_CNT
                                  : rsp_byte_index < SYNC_CNT))
      else $error("byte_index inconsistent with in_frame");

   // A stalled item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte)
                                  && $stable(rsp_byte_index))
      else $error("stalled result changed");

   // A stalled input item stays offered with the same byte.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_rx_byte))
      else $error("stalled input item changed");

endmodule : swfr_checker

bind sync_word_frame_receiver_checksum_top swfr_checker #(.FRAME_LEN(FRAME_LEN)) u_swfr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_rx_byte    (req_rx_byte),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_byte_index (rsp_byte_index),
   .rsp_in_frame   (rsp_in_frame),
   .rsp_frame_end  (rsp_frame_end),
   .rsp_frame_good (rsp_frame_good)
);

`default_nettype wire

[test/tb_sync_word_frame_receiver_checksum_top.sv]
// Self-checking testbench for the sync-word frame receiver with checksum.
`timescale 1ns / 1ps

module tb_sync_word_frame_receiver_checksum_top;

   localparam int FRAME_LEN  = swfr_pkg::FRAME_LEN_DEF;
   localparam int HOLD_TICKS = 80;
   localparam int N_PROBES   = 23;

   // One echoed byte with its frame marks.
   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic       in_frame;
      logic       frame_end;
      logic       frame_good;
   } rx_echo_type;

   // One row of the directed table; the echo is used only when typed is set.
   typedef struct packed {
      logic [7:0]  rx;
      logic        typed;
      rx_echo_type echo;
   } probe_row_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte    = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_byte_index;
   logic       rsp_in_frame;
   logic       rsp_frame_end;
   logic       rsp_frame_good;

   // Predicted receiver state.
   logic [2:0] hunt_pos  = swfr_pkg::SYNC_POS_HUNT;
   logic [7:0] body_idx  = 8'h00;
   logic [7:0] byte_sum  = 8'h00;
   logic [7:0] sum_sums  = 8'h00;
   logic       chk1_ok   = 1'b0;

   rx_echo_type expected_echoes[$];
   logic [7:0]  planned_bytes[$];
   int          items_sent     = 0;
   int          mismatch_count = 0;
   int          stall_left     = 0;
   logic        quiet          = 1'b0;
   logic        hold_rsp       = 1'b0;

   // Sync hunting first, then a partial frame left for the random part to finish.
   probe_row_type probe_rows [N_PROBES] = '{
      '{8'h00, 1'b1, '{8'h00, 8'd0, 1'b0, 1'b0, 1'b0}},
      '{8'hFF, 1'b1, '{8'hFF, 8'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h12, 1'b1, '{8'h12, 8'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h12, 1'b1, '{8'h12, 8'd1, 1'b0, 1'b0, 1'b0}},
      '{8'h12, 1'b1, '{8'h12, 8'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h34, 1'b1, '{8'h34, 8'd1, 1'b0, 1'b0, 1'b0}},
      '{8'h00, 1'b1, '{8'h00, 8'd2, 1'b0, 1'b0, 1'b0}},
      '{8'h12, 1'b1, '{8'h12, 8'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h34, 1'b1, '{8'h34, 8'd1, 1'b0, 1'b0, 1'b0}},
      '{8'h56, 1'b1, '{8'h56, 8'd2, 1'b0, 1'b0, 1'b0}},
      '{8'h77, 1'b1, '{8'h77, 8'd3, 1'b0, 1'b0, 1'b0}},
      '{8'h78, 1'b1, '{8'h78, 8'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h12, 1'b1, '{8'h12, 8'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h34, 1'b1, '{8'h34, 8'd1, 1'b0, 1'b0, 1'b0}},
      '{8'h56, 1'b1, '{8'h56, 8'd2, 1'b0, 1'b0, 1'b0}},
      '{8'h12, 1'b1, '{8'h12, 8'd3, 1'b0, 1'b0, 1'b0}},
      '{8'h34, 1'b1, '{8'h34, 8'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h12, 1'b1, '{8'h12, 8'd0, 1'b0, 1'b0, 1'b0}},
      '{8'h34, 1'b1, '{8'h34, 8'd1, 1'b0, 1'b0, 1'b0}},
      '{8'h56, 1'b1, '{8'h56, 8'd2, 1'b0, 1'b0, 1'b0}},
      '{8'h78, 1'b1, '{8'h78, 8'd3, 1'b0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0}
   };

   sync_word_frame_receiver_checksum_top #(
      .FRAME_LEN(FRAME_LEN)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_byte (rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_in_frame  (rsp_in_frame),
      .rsp_frame_end (rsp_frame_end),
      .rsp_frame_good(rsp_frame_good)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Both checksum sums advance by one byte.
   function automatic void fold_byte(input logic [7:0] b);
      byte_sum = byte_sum + b;
      sum_sums = sum_sums + byte_sum;
   endfunction

   function automatic void clear_sums();
      byte_sum = 8'h00;
      sum_sums = 8'h00;
      chk1_ok  = 1'b0;
   endfunction

   // Works out the echo of one accepted byte and advances the predicted state.
   function automatic rx_echo_type predict_echo(input logic [7:0] b);
      rx_echo_type e;
      e           = '0;
      e.data_byte = b;
      if (hunt_pos > swfr_pkg::SYNC_POS_BODY) hunt_pos = swfr_pkg::SYNC_POS_HUNT;
      if (hunt_pos < swfr_pkg::SYNC_POS_BODY) begin
         e.byte_index = {5'b0, hunt_pos};
         if (hunt_pos == swfr_pkg::SYNC_POS_HUNT) clear_sums();
         if (b == swfr_pkg::SYNC_WORD[hunt_pos[1:0]]) begin
            fold_byte(b);
            if (hunt_pos == swfr_pkg::SYNC_POS_LAST) body_idx = 8'(swfr_pkg::SYNC_LEN);
            hunt_pos = hunt_pos + 3'd1;
         end else begin
            // A mismatching byte is not retried as a first sync byte.
            hunt_pos = swfr_pkg::SYNC_POS_HUNT;
            clear_sums();
         end
      end else begin
         e.byte_index = body_idx;
         e.in_frame   = 1'b1;
         if (int'(body_idx) < FRAME_LEN - 2) begin
            fold_byte(b);
         end else if (int'(body_idx) == FRAME_LEN - 2) begin
            chk1_ok = (b == byte_sum);
         end else begin
            e.frame_end  = 1'b1;
            e.frame_good = chk1_ok && (b == sum_sums);
            hunt_pos     = swfr_pkg::SYNC_POS_HUNT;
            clear_sums();
         end
         body_idx = body_idx + 8'd1;
      end
      return e;
   endfunction

   function automatic logic [7:0] body_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Plans the next byte sequence from the current predicted state: the rest of a
   // frame already begun, else mostly whole frames with random bodies, some with
   // corrupted check bytes, plus broken sync words and noise.
   function automatic void plan_sequence();
      logic [7:0] sa, sb, b, wrong;
      int         kind, k, n;
      if (hunt_pos == swfr_pkg::SYNC_POS_BODY) begin
         for (int i = int'(body_idx); i < FRAME_LEN; i++) planned_bytes.push_back(body_byte());
         return;
      end
      // A zero byte breaks any partly matched sync word.
      if (hunt_pos != swfr_pkg::SYNC_POS_HUNT) planned_bytes.push_back(8'h00);
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         sa = 8'h00;
         sb = 8'h00;
         for (int i = 0; i < FRAME_LEN - 2; i++) begin
            b  = (i < swfr_pkg::SYNC_LEN) ? swfr_pkg::SYNC_WORD[i] : body_byte();
            sa = sa + b;
            sb = sb + sa;
            planned_bytes.push_back(b);
         end
         if (kind >= 60) begin
            k = $urandom_range(0, 2);
            if (k != 1) sa = sa ^ 8'($urandom_range(1, 255));
            if (k != 0) sb = sb ^ 8'($urandom_range(1, 255));
         end
         planned_bytes.push_back(sa);
         planned_bytes.push_back(sb);
      end else if (kind < 88) begin
         k = $urandom_range(0, swfr_pkg::SYNC_LEN - 1);
         for (int i = 0; i < k; i++) planned_bytes.push_back(swfr_pkg::SYNC_WORD[i]);
         do begin
            wrong = ($urandom_range(0, 2) == 0) ? swfr_pkg::SYNC_WORD[0]
                                                : 8'($urandom_range(0, 255));
         end while (wrong == swfr_pkg::SYNC_WORD[k]);
         planned_bytes.push_back(wrong);
      end else begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) planned_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // Offers one byte and waits until it is taken; called at a rising edge.
   task automatic send_item(input logic [7:0] b, input logic typed,
                            input rx_echo_type typed_echo);
      rx_echo_type e;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      e = predict_echo(b);
      if (typed) e = typed_echo;
      expected_echoes.push_back(e);
      items_sent++;
   endtask

   task automatic run_random(input int target);
      while (items_sent < target) begin
         if (planned_bytes.size() == 0) plan_sequence();
         send_item(planned_bytes.pop_front(), 1'b0, '0);
      end
   endtask

   // Drops valid and waits until every expected echo has arrived.
   task automatic drain_echoes();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_echoes.size() != 0);
   endtask

   // Compares one taken result with the oldest expectation.
   task automatic take_echo();
      rx_echo_type e;
      if (expected_echoes.size() == 0) begin
         $error("unexpected result: data_byte %0h index %0d", rsp_data_byte, rsp_byte_index);
         mismatch_count++;
         return;
      end
      e = expected_echoes.pop_front();
      if (rsp_data_byte !== e.data_byte) begin
         $error("data_byte: expected %0h, got %0h", e.data_byte, rsp_data_byte);
         mismatch_count++;
      end
      if (rsp_byte_index !== e.byte_index) begin
         $error("byte_index: expected %0d, got %0d", e.byte_index, rsp_byte_index);
         mismatch_count++;
      end
      if (rsp_in_frame !== e.in_frame) begin
         $error("in_frame: expected %0b, got %0b", e.in_frame, rsp_in_frame);
         mismatch_count++;
      end
      if (rsp_frame_end !== e.frame_end) begin
         $error("frame_end: expected %0b, got %0b", e.frame_end, rsp_frame_end);
         mismatch_count++;
      end
      if (rsp_frame_good !== e.frame_good) begin
         $error("frame_good: expected %0b, got %0b", e.frame_good, rsp_frame_good);
         mismatch_count++;
      end
   endtask

   // Result side: random stall bursts, one long hold on request, checks at the falling edge.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp   = 1'b0;
            stall_left = HOLD_TICKS;
         end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) take_echo();
      end
   end

   // Reset, directed table, then random phases with a long result hold and two drains.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_PROBES; i++) begin
         send_item(probe_rows[i].rx, probe_rows[i].typed, probe_rows[i].echo);
      end
      run_random(700);
      hold_rsp = 1'b1;
      run_random(760);
      drain_echoes();
      run_random(1450);
      quiet = 1'b1;
      run_random(1750);
      drain_echoes();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_sync_word_frame_receiver_checksum_top OK");
      end else begin
         $display("tb_sync_word_frame_receiver_checksum_top NOT OK");
      end
      $finish;
   end

   // Ends a hung run.
   initial begin
      #5000000;
      $display("tb_sync_word_frame_receiver_checksum_top NOT OK");
      $finish;
   end

endmodule
